### design/gasp_pkg.sv
// gasp_pkg: shared types and codes for the grid path search unit
// holds the sequencer state type, opcodes and status codes; no dependencies
package gasp_pkg;

   // sequencer states
   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_RD,
      S_CLR,
      S_SEED,
      S_POP,
      S_POPD,
      S_NB,
      S_NBD,
      S_INS,
      S_PUT,
      S_PATH,
      S_WALK
   } state_type;

   typedef logic [1:0] opcode_type;
   typedef logic [1:0] status_type;

   // request opcodes
   localparam opcode_type OP_WRITE   = 2'd0;
   localparam opcode_type OP_SEARCH  = 2'd1;
   localparam opcode_type OP_READ    = 2'd2;
   localparam opcode_type OP_UNKNOWN = 2'd3;

   // response status codes
   localparam status_type ST_WRITTEN = 2'd0;
   localparam status_type ST_FOUND   = 2'd1;
   localparam status_type ST_NOPATH  = 2'd2;
   localparam status_type ST_RANGE   = 2'd3;

   // neighbor order: right, left, up, down
   localparam logic [1:0] DIR_RIGHT = 2'd0;
   localparam logic [1:0] DIR_LEFT  = 2'd1;
   localparam logic [1:0] DIR_UP    = 2'd2;
   localparam logic [1:0] DIR_DOWN  = 2'd3;

endpackage

### design/gasp_ram.sv
// gasp_ram: generic simple dual port ram, one write and one registered read
// no dependencies
module gasp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

### design/grid_astar_path_search_unit.sv
// grid_astar_path_search_unit: best-first grid path search with cost map and path store
// depends on gasp_pkg and gasp_ram
//
// After reset the unit sweeps the cost map to zero, one cell a cycle, with busy high. A
// write, an unknown opcode or an out-of-range path read answers in the cycle after start;
// a path read in range answers through the S_RD state. A search first clears its visited
// map and seeds the open list, then takes each node off the open list (S_POP, S_POPD),
// fetches each neighbor inside the grid (S_NB, S_NBD) and skips those off the edge, puts
// an accepted neighbor straight in when the list is empty and else by a sorted insert that
// moves open-list entries up one place (S_INS, S_PUT), and at the goal walks back storing
// the path cells (S_PATH, S_WALK). Each result is a one-cycle rsp_valid strobe and must be
// taken in that cycle.
module grid_astar_path_search_unit #(
   parameter int GRID_X_BITS    = 5,
   parameter int GRID_Y_BITS    = 5,
   parameter int CELL_COST_BITS = 8,
   parameter int PATH_COST_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_opcode,
   input  logic [GRID_X_BITS-1:0]    req_pos_x,
   input  logic [GRID_Y_BITS-1:0]    req_pos_y,
   input  logic [CELL_COST_BITS-1:0] req_cell_cost,
   input  logic [GRID_X_BITS-1:0]    req_goal_x,
   input  logic [GRID_Y_BITS-1:0]    req_goal_y,
   input  logic [9:0]                req_path_index,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_status,
   output logic [9:0]                rsp_path_length,
   output logic [GRID_X_BITS-1:0]    rsp_step_x,
   output logic [GRID_Y_BITS-1:0]    rsp_step_y
);

   localparam int XB = GRID_X_BITS;
   localparam int YB = GRID_Y_BITS;
   localparam int AW = XB + YB;
   localparam int NC = 1 << AW;
   localparam int CW = AW + 1;
   localparam int P  = PATH_COST_BITS;
   localparam int C  = CELL_COST_BITS;
   localparam int SW = ((P > C) ? P : C) + 1;
   localparam int DW = (XB > YB) ? XB : YB;
   localparam int OW = 2 * P + 2 * AW;
   localparam int KW = 2 * AW;
   localparam logic [P-1:0]  COST_MAX   = '1;
   localparam logic [C-1:0]  BLOCK_COST = '1;
   localparam logic [CW-1:0] NC_CNT     = CW'(NC);
   localparam logic [XB-1:0] X_MAX      = '1;
   localparam logic [YB-1:0] Y_MAX      = '1;
   localparam logic [AW-1:0] SWEEP_LAST = '1;

   // dir_ff was already advanced when the insert began, so wrap means last direction done
   localparam logic [1:0] DIR_WRAP = 2'd0;

   // chebyshev distance to the goal plus cost, wrapping at path cost width
   function automatic logic [P-1:0] prio_of(input logic [AW-1:0] pos,
                                            input logic [AW-1:0] goal,
                                            input logic [P-1:0]  cost);
      logic [XB-1:0] x, gx, dx;
      logic [YB-1:0] y, gy, dy;
      logic [DW-1:0] d;
      logic [SW-1:0] s;
      x  = pos[XB-1:0];
      y  = pos[AW-1:XB];
      gx = goal[XB-1:0];
      gy = goal[AW-1:XB];
      dx = (x > gx) ? (x - gx) : (gx - x);
      dy = (y > gy) ? (y - gy) : (gy - y);
      d  = (DW'(dx) > DW'(dy)) ? DW'(dx) : DW'(dy);
      s  = SW'(d) + SW'(cost);
      return s[P-1:0];
   endfunction

   gasp_pkg::state_type state_ff, state_in;
   logic [AW-1:0]    sweep_ff, sweep_in;
   logic [AW-1:0]    start_ff, start_in;
   logic [AW-1:0]    goal_ff, goal_in;
   logic [AW-1:0]    cur_pos_ff, cur_pos_in;
   logic [P-1:0]     cur_cost_ff, cur_cost_in;
   logic [AW-1:0]    cur_idx_ff, cur_idx_in;
   logic [1:0]       dir_ff, dir_in;
   logic [AW-1:0]    nb_pos_ff, nb_pos_in;
   logic [OW-1:0]    new_node_ff, new_node_in;
   logic [CW-1:0]    ins_ff, ins_in;
   logic [CW-1:0]    open_cnt_ff, open_cnt_in;
   logic [CW-1:0]    closed_cnt_ff, closed_cnt_in;
   logic [CW-1:0]    path_cnt_ff, path_cnt_in;
   logic [CW-1:0]    steps_ff, steps_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [XB-1:0]    rsp_x_ff, rsp_x_in;
   logic [YB-1:0]    rsp_y_ff, rsp_y_in;

   // memory ports
   logic          cost_we;
   logic [AW-1:0] cost_waddr, cost_raddr;
   logic [C-1:0]  cost_wdata, cost_rdata;
   logic          seen_we;
   logic [AW-1:0] seen_waddr, seen_raddr;
   logic [0:0]    seen_wdata, seen_rdata;
   logic          open_we;
   logic [AW-1:0] open_waddr, open_raddr;
   logic [OW-1:0] open_wdata, open_rdata;
   logic          closed_we;
   logic [AW-1:0] closed_waddr, closed_raddr;
   logic [KW-1:0] closed_wdata, closed_rdata;
   logic          path_we;
   logic [AW-1:0] path_waddr, path_raddr;
   logic [AW-1:0] path_wdata, path_rdata;

   gasp_ram #(.WIDTH(C), .DEPTH(NC)) u_cost_ram (
      .clock(clock), .we(cost_we), .waddr(cost_waddr), .wdata(cost_wdata),
      .raddr(cost_raddr), .rdata(cost_rdata));

   gasp_ram #(.WIDTH(1), .DEPTH(NC)) u_seen_ram (
      .clock(clock), .we(seen_we), .waddr(seen_waddr), .wdata(seen_wdata),
      .raddr(seen_raddr), .rdata(seen_rdata));

   gasp_ram #(.WIDTH(OW), .DEPTH(NC)) u_open_ram (
      .clock(clock), .we(open_we), .waddr(open_waddr), .wdata(open_wdata),
      .raddr(open_raddr), .rdata(open_rdata));

   gasp_ram #(.WIDTH(KW), .DEPTH(NC)) u_closed_ram (
      .clock(clock), .we(closed_we), .waddr(closed_waddr), .wdata(closed_wdata),
      .raddr(closed_raddr), .rdata(closed_rdata));

   gasp_ram #(.WIDTH(AW), .DEPTH(NC)) u_path_ram (
      .clock(clock), .we(path_we), .waddr(path_waddr), .wdata(path_wdata),
      .raddr(path_raddr), .rdata(path_rdata));

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gasp_pkg::S_INIT;
         sweep_ff      <= '0;
         open_cnt_ff   <= '0;
         closed_cnt_ff <= '0;
         path_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         open_cnt_ff   <= open_cnt_in;
         closed_cnt_ff <= closed_cnt_in;
         path_cnt_ff   <= path_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      start_ff      <= start_in;
      goal_ff       <= goal_in;
      cur_pos_ff    <= cur_pos_in;
      cur_cost_ff   <= cur_cost_in;
      cur_idx_ff    <= cur_idx_in;
      dir_ff        <= dir_in;
      nb_pos_ff     <= nb_pos_in;
      new_node_ff   <= new_node_in;
      ins_ff        <= ins_in;
      steps_ff      <= steps_in;
      rsp_status_ff <= rsp_status_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
   end

   // sequencer: next state, memory controls and responses
   always_comb begin
      logic [31:0]     pi_ext;
      logic [SW-1:0]   cext;
      logic [SW-1:0]   sum;
      logic [P-1:0]    ncost;
      logic [XB-1:0]   cx, nx;
      logic [YB-1:0]   cy, ny;
      logic            nb_ok;
      logic [P-1:0]    odata_prio;
      logic [AW-1:0]   walk_pos, walk_prev;
      gasp_pkg::state_type after_nb;

      state_in      = state_ff;
      sweep_in      = sweep_ff;
      start_in      = start_ff;
      goal_in       = goal_ff;
      cur_pos_in    = cur_pos_ff;
      cur_cost_in   = cur_cost_ff;
      cur_idx_in    = cur_idx_ff;
      dir_in        = dir_ff;
      nb_pos_in     = nb_pos_ff;
      new_node_in   = new_node_ff;
      ins_in        = ins_ff;
      open_cnt_in   = open_cnt_ff;
      closed_cnt_in = closed_cnt_ff;
      path_cnt_in   = path_cnt_ff;
      steps_in      = steps_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;

      cost_we      = 1'b0;
      cost_waddr   = sweep_ff;
      cost_wdata   = '0;
      cost_raddr   = start_ff;
      seen_we      = 1'b0;
      seen_waddr   = sweep_ff;
      seen_wdata   = 1'b0;
      seen_raddr   = nb_pos_ff;
      open_we      = 1'b0;
      open_waddr   = ins_ff[AW-1:0];
      open_wdata   = new_node_ff;
      open_raddr   = ins_ff[AW-1:0];
      closed_we    = 1'b0;
      closed_waddr = closed_cnt_ff[AW-1:0];
      closed_wdata = {cur_pos_ff, cur_idx_ff};
      closed_raddr = cur_idx_ff;
      path_we      = 1'b0;
      path_waddr   = path_cnt_ff[AW-1:0];
      path_wdata   = cur_pos_ff;
      path_raddr   = '0;

      pi_ext     = 32'(req_path_index);
      cext       = SW'(cost_rdata);
      sum        = SW'(cur_cost_ff) + SW'(cost_rdata);
      ncost      = sum[P-1:0];
      cx         = cur_pos_ff[XB-1:0];
      cy         = cur_pos_ff[AW-1:XB];
      nx         = cx;
      ny         = cy;
      nb_ok      = 1'b0;
      odata_prio = open_rdata[OW-1 -: P];
      walk_pos   = closed_rdata[KW-1:AW];
      walk_prev  = closed_rdata[AW-1:0];
      after_nb   = (dir_ff == gasp_pkg::DIR_DOWN) ? gasp_pkg::S_POP : gasp_pkg::S_NB;

      // neighbor coordinates for the current direction
      case (dir_ff)
         gasp_pkg::DIR_RIGHT: begin
            nx    = cx + XB'(1);
            nb_ok = (cx != X_MAX);
         end
         gasp_pkg::DIR_LEFT: begin
            nx    = cx - XB'(1);
            nb_ok = (cx != '0);
         end
         gasp_pkg::DIR_UP: begin
            ny    = cy - YB'(1);
            nb_ok = (cy != '0);
         end
         default: begin
            ny    = cy + YB'(1);
            nb_ok = (cy != Y_MAX);
         end
      endcase

      case (state_ff)
         // clear the cost map after reset
         gasp_pkg::S_INIT: begin
            cost_we  = 1'b1;
            sweep_in = sweep_ff + AW'(1);
            if (sweep_ff == SWEEP_LAST) begin
               state_in = gasp_pkg::S_IDLE;
            end
         end

         // take a new request word
         gasp_pkg::S_IDLE: begin
            if (start) begin
               rsp_x_in = '0;
               rsp_y_in = '0;
               case (req_opcode)
                  gasp_pkg::OP_WRITE: begin
                     cost_we       = 1'b1;
                     cost_waddr    = {req_pos_y, req_pos_x};
                     cost_wdata    = req_cell_cost;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = gasp_pkg::ST_WRITTEN;
                  end
                  gasp_pkg::OP_SEARCH: begin
                     start_in = {req_pos_y, req_pos_x};
                     goal_in  = {req_goal_y, req_goal_x};
                     sweep_in = '0;
                     state_in = gasp_pkg::S_CLR;
                  end
                  gasp_pkg::OP_READ: begin
                     if (pi_ext < 32'(path_cnt_ff)) begin
                        path_raddr = pi_ext[AW-1:0];
                        state_in   = gasp_pkg::S_RD;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = gasp_pkg::ST_RANGE;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = gasp_pkg::ST_RANGE;
                  end
               endcase
            end
         end

         // path entry read data is back
         gasp_pkg::S_RD: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = gasp_pkg::ST_FOUND;
            rsp_x_in      = path_rdata[XB-1:0];
            rsp_y_in      = path_rdata[AW-1:XB];
            state_in      = gasp_pkg::S_IDLE;
         end

         // clear visited marks, then fetch the start cost
         gasp_pkg::S_CLR: begin
            seen_we  = 1'b1;
            sweep_in = sweep_ff + AW'(1);
            if (sweep_ff == SWEEP_LAST) begin
               state_in = gasp_pkg::S_SEED;
            end
         end

         // push the start node
         gasp_pkg::S_SEED: begin
            ncost         = (cext > SW'(COST_MAX)) ? COST_MAX : cext[P-1:0];
            open_we       = 1'b1;
            open_waddr    = '0;
            open_wdata    = {prio_of(start_ff, goal_ff, ncost), ncost, start_ff, AW'(0)};
            seen_we       = 1'b1;
            seen_waddr    = start_ff;
            seen_wdata    = 1'b1;
            open_cnt_in   = CW'(1);
            closed_cnt_in = '0;
            state_in      = gasp_pkg::S_POP;
         end

         // take the best node off the open list, or report no path when it is empty
         gasp_pkg::S_POP: begin
            if (open_cnt_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = gasp_pkg::ST_NOPATH;
               state_in      = gasp_pkg::S_IDLE;
            end else begin
               open_raddr  = open_cnt_ff[AW-1:0] - AW'(1);
               open_cnt_in = open_cnt_ff - CW'(1);
               state_in    = gasp_pkg::S_POPD;
            end
         end

         // close the node and test for the goal
         gasp_pkg::S_POPD: begin
            closed_we     = 1'b1;
            closed_wdata  = open_rdata[KW-1:0];
            cur_idx_in    = closed_cnt_ff[AW-1:0];
            closed_cnt_in = closed_cnt_ff + CW'(1);
            cur_pos_in    = open_rdata[KW-1:AW];
            cur_cost_in   = open_rdata[KW+P-1:KW];
            dir_in        = gasp_pkg::DIR_RIGHT;
            if (open_rdata[KW-1:AW] == goal_ff) begin
               state_in = gasp_pkg::S_PATH;
            end else begin
               state_in = gasp_pkg::S_NB;
            end
         end

         // fetch cost and visited mark of the neighbor
         gasp_pkg::S_NB: begin
            nb_pos_in  = {ny, nx};
            cost_raddr = {ny, nx};
            seen_raddr = {ny, nx};
            if (nb_ok) begin
               state_in = gasp_pkg::S_NBD;
            end else begin
               dir_in   = dir_ff + 2'd1;
               state_in = after_nb;
            end
         end

         // accept or skip the neighbor
         gasp_pkg::S_NBD: begin
            dir_in = dir_ff + 2'd1;
            if (cost_rdata == BLOCK_COST || sum > SW'(COST_MAX) || seen_rdata[0]) begin
               state_in = after_nb;
            end else begin
               new_node_in = {prio_of(nb_pos_ff, goal_ff, ncost), ncost, nb_pos_ff, cur_idx_ff};
               seen_we     = 1'b1;
               seen_waddr  = nb_pos_ff;
               seen_wdata  = 1'b1;
               ins_in      = open_cnt_ff;
               if (open_cnt_ff == '0) begin
                  open_we     = 1'b1;
                  open_waddr  = '0;
                  open_wdata  = new_node_in;
                  open_cnt_in = open_cnt_ff + CW'(1);
                  state_in    = after_nb;
               end else begin
                  open_raddr = open_cnt_ff[AW-1:0] - AW'(1);
                  state_in   = gasp_pkg::S_INS;
               end
            end
         end

         // sorted insert: move lower priorities up one place
         gasp_pkg::S_INS: begin
            open_we = 1'b1;
            if (odata_prio < new_node_ff[OW-1 -: P]) begin
               open_wdata = open_rdata;
               ins_in     = ins_ff - CW'(1);
               if (ins_ff == CW'(1)) begin
                  state_in = gasp_pkg::S_PUT;
               end else begin
                  open_raddr = ins_ff[AW-1:0] - AW'(2);
               end
            end else begin
               open_cnt_in = open_cnt_ff + CW'(1);
               state_in    = (dir_ff == DIR_WRAP) ? gasp_pkg::S_POP : gasp_pkg::S_NB;
            end
         end

         // new node goes to the bottom of the list
         gasp_pkg::S_PUT: begin
            open_we     = 1'b1;
            open_cnt_in = open_cnt_ff + CW'(1);
            state_in    = (dir_ff == DIR_WRAP) ? gasp_pkg::S_POP : gasp_pkg::S_NB;
         end

         // start the walk back from the goal
         gasp_pkg::S_PATH: begin
            path_cnt_in = '0;
            steps_in    = '0;
            state_in    = gasp_pkg::S_WALK;
         end

         // store one path cell a cycle until the start is reached or the step limit is hit
         gasp_pkg::S_WALK: begin
            if (walk_pos == start_ff || steps_ff == NC_CNT) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = gasp_pkg::ST_FOUND;
               state_in      = gasp_pkg::S_IDLE;
            end else begin
               if (path_cnt_ff < NC_CNT) begin
                  path_we     = 1'b1;
                  path_wdata  = walk_pos;
                  path_cnt_in = path_cnt_ff + CW'(1);
               end
               steps_in     = steps_ff + CW'(1);
               closed_raddr = walk_prev;
            end
         end

         default: begin
            state_in = gasp_pkg::S_IDLE;
         end
      endcase
   end

   // outputs
   logic [31:0] path_len_ext;
   assign path_len_ext    = 32'(path_cnt_ff);
   assign busy            = (state_ff != gasp_pkg::S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_path_length = path_len_ext[9:0];
   assign rsp_step_x      = rsp_x_ff;
   assign rsp_step_y      = rsp_y_ff;

endmodule

### verif/tb_grid_astar_path_search_unit.sv
// tb_grid_astar_path_search_unit: self-checking bench for the grid path search unit
// depends on gasp_pkg and grid_astar_path_search_unit; every response word is checked
// against a built-in predictor or typed table row, directed table first, then random
module tb_grid_astar_path_search_unit;

   localparam int NCELL = 1024;
   localparam int IDLE_LIMIT = 5000000;

   typedef struct {
      gasp_pkg::opcode_type op;
      logic [4:0] px, py;
      logic [7:0] cc;
      logic [4:0] gx, gy;
      logic [9:0] pi;
      bit         typed;
      gasp_pkg::status_type st;
      logic [9:0] len;
   } stim_row_type;

   typedef struct {
      gasp_pkg::status_type st;
      logic [9:0] len;
      logic [4:0] sx, sy;
   } rsp_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [1:0] req_opcode = gasp_pkg::OP_WRITE;
   logic [4:0] req_pos_x = '0, req_pos_y = '0, req_goal_x = '0, req_goal_y = '0;
   logic [7:0] req_cell_cost = '0;
   logic [9:0] req_path_index = '0;
   logic       rsp_valid;
   logic [1:0] rsp_status;
   logic [9:0] rsp_path_length;
   logic [4:0] rsp_step_x, rsp_step_y;

   // model state of the search unit
   int unsigned cost_cells[NCELL];
   int unsigned open_prio[NCELL], open_cost[NCELL], open_pos[NCELL], open_prev[NCELL];
   int unsigned shut_pos[NCELL], shut_prev[NCELL];
   bit          visited[NCELL];
   int unsigned open_n, shut_n;
   int unsigned route[NCELL];
   int unsigned route_n;

   rsp_word_type pending_rsp[$];
   int          errors = 0;
   int          idle_cycles = 0;
   int          n_write = 0, n_search = 0, n_read = 0, n_found = 0, n_rsp = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   grid_astar_path_search_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_cell_cost(req_cell_cost), .req_goal_x(req_goal_x), .req_goal_y(req_goal_y),
      .req_path_index(req_path_index), .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_path_length(rsp_path_length), .rsp_step_x(rsp_step_x), .rsp_step_y(rsp_step_y)
   );

   // chebyshev distance plus cost, kept in 16 bits
   function automatic int unsigned rank_of(int x, int y, int gx, int gy, int unsigned c);
      int dx, dy;
      dx = (x > gx) ? x - gx : gx - x;
      dy = (y > gy) ? y - gy : gy - y;
      return ((dx > dy ? dx : dy) + c) & 16'hFFFF;
   endfunction

   // offer one neighbor to the sorted open list
   function automatic void offer_cell(int unsigned prev, int nx, int ny, int gx, int gy,
                                      int unsigned cur);
      int unsigned p, c, sum, r;
      int          i;
      if (nx < 0 || ny < 0 || nx > 31 || ny > 31) return;
      p = (ny << 5) | nx;
      c = cost_cells[p];
      if (c == 255) return;
      sum = cur + c;
      if (sum > 16'hFFFF) return;
      if (visited[p] || open_n >= NCELL) return;
      r = rank_of(nx, ny, gx, gy, sum);
      i = open_n;
      while (i > 0 && open_prio[i-1] < r) begin
         open_prio[i] = open_prio[i-1];
         open_cost[i] = open_cost[i-1];
         open_pos[i]  = open_pos[i-1];
         open_prev[i] = open_prev[i-1];
         i--;
      end
      open_prio[i] = r;
      open_cost[i] = sum;
      open_pos[i]  = p;
      open_prev[i] = prev;
      visited[p]   = 1'b1;
      open_n++;
   endfunction

   // best-first search; stores the route goal-first when the goal is reached
   function automatic bit find_route(int sx, int sy, int gx, int gy);
      int unsigned src, dst, idx, c, p, cur, steps;
      bit          hit;
      int          x, y;
      src = (sy << 5) | sx;
      dst = (gy << 5) | gx;
      hit = 1'b0;
      idx = 0;
      foreach (visited[k]) visited[k] = 1'b0;
      shut_n = 0;
      open_prio[0] = rank_of(sx, sy, gx, gy, cost_cells[src]);
      open_cost[0] = cost_cells[src];
      open_pos[0]  = src;
      open_prev[0] = 0;
      visited[src] = 1'b1;
      open_n = 1;
      while (open_n > 0 && shut_n < NCELL) begin
         open_n--;
         p = open_pos[open_n];
         c = open_cost[open_n];
         idx = shut_n;
         shut_pos[shut_n]  = p;
         shut_prev[shut_n] = open_prev[open_n];
         shut_n++;
         if (p == dst) begin
            hit = 1'b1;
            break;
         end
         x = p & 31;
         y = p >> 5;
         offer_cell(idx, x + 1, y, gx, gy, c);
         offer_cell(idx, x - 1, y, gx, gy, c);
         offer_cell(idx, x, y - 1, gx, gy, c);
         offer_cell(idx, x, y + 1, gx, gy, c);
      end
      if (!hit) return 1'b0;
      route_n = 0;
      cur = idx;
      steps = 0;
      while (cur < shut_n && shut_pos[cur] != src && steps < NCELL) begin
         route[route_n++] = shut_pos[cur];
         cur = shut_prev[cur];
         steps++;
      end
      return 1'b1;
   endfunction

   // expected response word for one accepted request
   function automatic rsp_word_type predict_rsp(gasp_pkg::opcode_type op, int px, int py,
                                                int cc, int gx, int gy, int pi);
      rsp_word_type w;
      w.sx = '0;
      w.sy = '0;
      case (op)
         gasp_pkg::OP_WRITE: begin
            cost_cells[(py << 5) | px] = cc;
            w.st = gasp_pkg::ST_WRITTEN;
         end
         gasp_pkg::OP_SEARCH: begin
            w.st = find_route(px, py, gx, gy) ? gasp_pkg::ST_FOUND : gasp_pkg::ST_NOPATH;
         end
         gasp_pkg::OP_READ: begin
            if (pi < route_n) begin
               w.sx = 5'(route[pi] & 31);
               w.sy = 5'((route[pi] >> 5) & 31);
               w.st = gasp_pkg::ST_FOUND;
            end else begin
               w.st = gasp_pkg::ST_RANGE;
            end
         end
         default: w.st = gasp_pkg::ST_RANGE;
      endcase
      w.len = 10'(route_n);
      return w;
   endfunction

   // random idle gap: mostly none or short, sometimes long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // drive one request word and wait for it to be taken
   task automatic issue(stim_row_type row);
      rsp_word_type w;
      int        gap;
      req_opcode     <= row.op;
      req_pos_x      <= row.px;
      req_pos_y      <= row.py;
      req_cell_cost  <= row.cc;
      req_goal_x     <= row.gx;
      req_goal_y     <= row.gy;
      req_path_index <= row.pi;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      w = predict_rsp(row.op, row.px, row.py, row.cc, row.gx, row.gy, row.pi);
      if (row.typed && (w.st !== row.st || w.len !== row.len))
         $display("%0t table row disagrees with predictor: status %0d/%0d len %0d/%0d",
                  $time, row.st, w.st, row.len, w.len);
      if (row.typed) begin
         w.st  = row.st;
         w.len = row.len;
      end
      pending_rsp.push_back(w);
      case (row.op)
         gasp_pkg::OP_WRITE:  n_write++;
         gasp_pkg::OP_SEARCH: n_search++;
         gasp_pkg::OP_READ:   n_read++;
         default:   ;
      endcase
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // response checker and stall watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t unexpected response word status %0d", $time, rsp_status);
               errors++;
            end else begin
               if (rsp_status !== pending_rsp[0].st ||
                   rsp_path_length !== pending_rsp[0].len ||
                   rsp_step_x !== pending_rsp[0].sx || rsp_step_y !== pending_rsp[0].sy) begin
                  $display("%0t mismatch: expected st %0d len %0d x %0d y %0d,",
                           $time, pending_rsp[0].st, pending_rsp[0].len, pending_rsp[0].sx,
                           pending_rsp[0].sy);
                  $display("   got st %0d len %0d x %0d y %0d",
                           rsp_status, rsp_path_length, rsp_step_x, rsp_step_y);
                  errors++;
               end
               void'(pending_rsp.pop_front());
            end
            if (rsp_status == gasp_pkg::ST_FOUND) n_found++;
            n_rsp++;
         end
         if (rsp_valid || (start && !busy)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired with %0d words outstanding", pending_rsp.size());
            $display("FAIL");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // directed table: extremes, every opcode, blocked goal and start, empty path
   stim_row_type dir_tab[] = '{
      '{gasp_pkg::OP_READ,    0,  0,   0,  0,  0,    0, 1, gasp_pkg::ST_RANGE,   0},
      '{gasp_pkg::OP_UNKNOWN,31, 31, 255, 31, 31, 1023, 1, gasp_pkg::ST_RANGE,   0},
      '{gasp_pkg::OP_SEARCH,  0,  0,   0,  0,  0,    0, 1, gasp_pkg::ST_FOUND,   0},
      '{gasp_pkg::OP_WRITE,  31, 31, 255,  0,  0,    0, 1, gasp_pkg::ST_WRITTEN, 0},
      '{gasp_pkg::OP_SEARCH,  0,  0,   0, 31, 31,    0, 1, gasp_pkg::ST_NOPATH,  0},
      '{gasp_pkg::OP_WRITE,  31, 31,   0,  0,  0,    0, 1, gasp_pkg::ST_WRITTEN, 0},
      '{gasp_pkg::OP_SEARCH,  0,  0,   0,  1,  0,    0, 1, gasp_pkg::ST_FOUND,   1},
      '{gasp_pkg::OP_READ,    0,  0,   0,  0,  0,    0, 0, gasp_pkg::ST_FOUND,   0},
      '{gasp_pkg::OP_READ,    0,  0,   0,  0,  0,    1, 1, gasp_pkg::ST_RANGE,   1},
      '{gasp_pkg::OP_READ,   31, 31, 255, 31, 31, 1023, 1, gasp_pkg::ST_RANGE,   1},
      '{gasp_pkg::OP_WRITE,  30, 30, 255,  0,  0,    0, 1, gasp_pkg::ST_WRITTEN, 1},
      '{gasp_pkg::OP_SEARCH, 30, 30,   0, 31, 30,    0, 0, gasp_pkg::ST_FOUND,   0},
      '{gasp_pkg::OP_WRITE,   1,  1, 254,  0,  0,    0, 1, gasp_pkg::ST_WRITTEN, 1},
      '{gasp_pkg::OP_WRITE,   1,  0, 200,  0,  0,    0, 1, gasp_pkg::ST_WRITTEN, 1},
      '{gasp_pkg::OP_SEARCH,  0,  0,   0, 31, 31,    0, 0, gasp_pkg::ST_FOUND,   0},
      '{gasp_pkg::OP_READ,    0,  0,   0,  0,  0,    5, 0, gasp_pkg::ST_FOUND,   0},
      '{gasp_pkg::OP_SEARCH, 31,  0,   0,  0, 31,    0, 0, gasp_pkg::ST_FOUND,   0},
      '{gasp_pkg::OP_READ,    0,  0,   0,  0,  0,   20, 0, gasp_pkg::ST_FOUND,   0}
   };

   initial begin
      stim_row_type row;
      int        r, k;
      foreach (cost_cells[k0]) cost_cells[k0] = 0;
      route_n = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) issue(dir_tab[i]);

      // random traffic: obstacles mostly in a small corner so searches detour
      for (k = 0; k < 85; k++) begin
         row = '{default: '0};
         row.px = 5'($urandom);
         row.py = 5'($urandom);
         row.gx = 5'($urandom);
         row.gy = 5'($urandom);
         row.pi = 10'($urandom);
         row.cc = 8'($urandom);
         r = $urandom_range(99);
         if (r < 55) begin
            row.op = gasp_pkg::OP_WRITE;
            if ($urandom_range(9) < 7) begin
               row.px = 5'($urandom_range(7));
               row.py = 5'($urandom_range(7));
            end
            case ($urandom_range(4))
               0: row.cc = 8'd0;
               1: row.cc = 8'd255;
               2: row.cc = 8'($urandom_range(1, 20));
               3: row.cc = 8'd254;
               default: ;
            endcase
         end else if (r < 80) begin
            row.op = gasp_pkg::OP_SEARCH;
            if ($urandom_range(1)) begin
               row.px = 5'($urandom_range(7));
               row.py = 5'($urandom_range(7));
               row.gx = 5'($urandom_range(7));
               row.gy = 5'($urandom_range(7));
            end
         end else if (r < 97) begin
            row.op = gasp_pkg::OP_READ;
            if (route_n > 0 && $urandom_range(9) < 7) row.pi = 10'($urandom_range(route_n - 1));
         end else begin
            row.op = gasp_pkg::OP_UNKNOWN;
         end
         issue(row);
      end

      start <= 1'b0;
      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d writes, %0d searches, %0d reads; %0d responses, %0d found/valid",
               n_write, n_search, n_read, n_rsp, n_found);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
design/gasp_pkg.sv
design/gasp_ram.sv
design/grid_astar_path_search_unit.sv
verif/tb_grid_astar_path_search_unit.sv
